// ===== sv/scmips_pkg.sv =====
// Shared types and codes for the MIPS subset core.
// Holds action, write-kind, opcode and funct codes plus the execute result struct.
// No dependencies.
package scmips_pkg;

  // Item actions
  localparam logic [1:0] ACT_EXEC  = 2'd0;
  localparam logic [1:0] ACT_LDREG = 2'd1;
  localparam logic [1:0] ACT_LDMEM = 2'd2;

  // Kinds of write reported with a result
  localparam logic [1:0] WK_NONE = 2'd0;
  localparam logic [1:0] WK_REG  = 2'd1;
  localparam logic [1:0] WK_MEM  = 2'd2;

  // Opcodes
  localparam logic [5:0] OP_RTYPE = 6'b000000;
  localparam logic [5:0] OP_LW    = 6'b100011;
  localparam logic [5:0] OP_SW    = 6'b101011;
  localparam logic [5:0] OP_BEQ   = 6'b000100;
  localparam logic [5:0] OP_J     = 6'b000010;
  localparam logic [5:0] OP_JAL   = 6'b000011;

  // R-type functs
  localparam logic [5:0] FN_ADD = 6'b100000;
  localparam logic [5:0] FN_SUB = 6'b100010;
  localparam logic [5:0] FN_AND = 6'b100100;
  localparam logic [5:0] FN_OR  = 6'b100101;
  localparam logic [5:0] FN_NOR = 6'b100111;
  localparam logic [5:0] FN_SLT = 6'b101010;

  // What one transaction does, as worked out by the execute stage
  typedef struct packed {
    logic [31:0] npc;
    logic [31:0] cnt;
    logic        redir;
    logic        bad;
    logic        rf_we;
    logic        rf_ld;
    logic [4:0]  rf_dst;
    logic [31:0] rf_val;
    logic        dm_we;
    logic [29:0] dm_word;
    logic [31:0] dm_val;
  } ex_t;

endpackage

// ===== sv/single_cycle_mips_subset_core.sv =====
// A transaction accepted into stage 1 moves through stages 2 and 3 into the stage 4 result register.
// Throughput: one transaction per cycle while out_stall is low; an instruction that reads the
// destination of an lw one or two transactions ahead is held until the load data is out.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the register file and data
// memory, with in_stall high throughout.
// Depends on scmips_pkg, scmips_exec and scmips_ram.
module single_cycle_mips_subset_core #(
  parameter int DMEM_WORDS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [31:0]        in_instruction_word,
  input  logic [4:0]         in_load_index,
  input  logic signed [31:0] in_load_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_next_pc,
  output logic [1:0]         out_write_kind,
  output logic [4:0]         out_write_target,
  output logic signed [31:0] out_write_value,
  output logic               out_redirected,
  output logic               out_illegal,
  output logic [31:0]        out_executed_count
);
  import scmips_pkg::*;

  localparam int RF_DEPTH = 32;
  localparam int DM_AW    = $clog2(DMEM_WORDS);
  localparam int CLR_N    = (DMEM_WORDS > RF_DEPTH) ? DMEM_WORDS : RF_DEPTH;
  localparam int CLR_W    = $clog2(CLR_N);
  localparam int WORD_W   = 30;
  localparam int SHIFT    = WORD_W + DM_AW;
  // Reciprocal for an exact word / DMEM_WORDS over all 30-bit word numbers
  localparam logic [63:0] MAGIC64 =
      ((64'd1 << SHIFT) + 64'(DMEM_WORDS) - 64'd1) / 64'(DMEM_WORDS);
  localparam logic [31:0] MAGIC = MAGIC64[31:0];

  typedef struct packed {
    logic        haz;
    logic [31:0] val;
  } fwd_t;

  // Clearing pass
  logic             clearing_r;
  logic [CLR_W-1:0] clr_cnt_r;

  // Stage 1: accepted transaction
  logic        s1_v_r;
  logic [1:0]  s1_action_r;
  logic [31:0] s1_insn_r;
  logic [4:0]  s1_lidx_r;
  logic [31:0] s1_lval_r;

  logic [31:0] pc_r;
  logic [31:0] count_r;

  // Stages 2..4 (stage 4 is the result register)
  ex_t               s2_r, s3_r, s4_r;
  logic              s2_v_r, s3_v_r, s4_v_r;
  logic [WORD_W-1:0] s3_q_r;
  logic [4:0]        s4_tgt_r;

  // Register write made at the last edge, unseen by the read issued at that edge
  logic        wb_v_r;
  logic [4:0]  wb_idx_r;
  logic [31:0] wb_val_r;

  logic [31:0] rf_a_q, rf_b_q, dm_q;

  ex_t                 ex;
  fwd_t                fa, fb;
  logic                haz;
  logic                en_pipe;
  logic                s1_adv;
  logic                s1_hold;
  logic                in_acc;
  logic                commit;
  logic                rf_commit;
  logic [31:0]         commit_val;
  logic [4:0]          rs_addr, rt_addr;
  logic                rf_we;
  logic [4:0]          rf_waddr;
  logic [31:0]         rf_wdata;
  logic [2*WORD_W+1:0] prod;
  logic [WORD_W-1:0]   q_nxt;
  logic [WORD_W-1:0]   rem;
  logic [DM_AW-1:0]    dm_idx;
  logic                dm_we;
  logic [DM_AW-1:0]    dm_waddr;
  logic [31:0]         dm_wdata;

  // Youngest pending write to idx wins; an lw still short of its data raises haz
  function automatic fwd_t fwd(input logic [4:0] idx, input logic [31:0] ram);
    fwd_t r;
    r.haz = 1'b0;
    r.val = ram;
    if (s2_v_r && s2_r.rf_we && s2_r.rf_dst == idx) begin
      r.haz = s2_r.rf_ld;
      r.val = s2_r.rf_val;
    end else if (s3_v_r && s3_r.rf_we && s3_r.rf_dst == idx) begin
      r.haz = s3_r.rf_ld;
      r.val = s3_r.rf_val;
    end else if (s4_v_r && s4_r.rf_we && s4_r.rf_dst == idx) begin
      r.val = s4_r.rf_ld ? dm_q : s4_r.rf_val;
    end else if (wb_v_r && wb_idx_r == idx) begin
      r.val = wb_val_r;
    end
    return r;
  endfunction

  always_comb begin
    fa  = fwd(s1_insn_r[25:21], rf_a_q);
    fb  = fwd(s1_insn_r[20:16], rf_b_q);
    haz = s1_v_r && (s1_action_r == ACT_EXEC) && (fa.haz || fb.haz);
  end

  assign en_pipe  = !(s4_v_r && out_stall);
  assign s1_adv   = s1_v_r && en_pipe && !haz;
  assign s1_hold  = s1_v_r && !s1_adv;
  assign in_stall = clearing_r || s1_hold;
  assign in_acc   = in_valid && !in_stall;

  // Re-read the held transaction's operands every cycle so commits are never missed
  assign rs_addr = s1_hold ? s1_insn_r[25:21] : in_instruction_word[25:21];
  assign rt_addr = s1_hold ? s1_insn_r[20:16] : in_instruction_word[20:16];

  scmips_exec u_exec (
    .action_i (s1_action_r),
    .insn_i   (s1_insn_r),
    .lidx_i   (s1_lidx_r),
    .lval_i   (s1_lval_r),
    .pc_i     (pc_r),
    .cnt_i    (count_r),
    .a_i      (fa.val),
    .b_i      (fb.val),
    .ex_o     (ex)
  );

  // Word index modulo DMEM_WORDS: reciprocal multiply, then back-multiply and subtract
  assign prod   = (2*WORD_W+2)'(s2_r.dm_word) * (2*WORD_W+2)'(MAGIC);
  assign q_nxt  = WORD_W'(prod >> SHIFT);
  assign rem    = s3_r.dm_word - WORD_W'(s3_q_r * WORD_W'(DMEM_WORDS));
  assign dm_idx = rem[DM_AW-1:0];

  // Register file commit when the result transaction leaves
  assign commit     = s4_v_r && !out_stall;
  assign rf_commit  = commit && s4_r.rf_we;
  assign commit_val = s4_r.rf_ld ? dm_q : s4_r.rf_val;

  assign rf_we    = clearing_r ? (32'(clr_cnt_r) < RF_DEPTH) : rf_commit;
  assign rf_waddr = clearing_r ? clr_cnt_r[4:0] : s4_r.rf_dst;
  assign rf_wdata = clearing_r ? 32'd0 : commit_val;

  assign dm_we    = clearing_r ? (32'(clr_cnt_r) < DMEM_WORDS)
                               : (en_pipe && s3_v_r && s3_r.dm_we);
  assign dm_waddr = clearing_r ? clr_cnt_r[DM_AW-1:0] : dm_idx;
  assign dm_wdata = clearing_r ? 32'd0 : s3_r.dm_val;

  scmips_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (1'b1),
    .raddr (rs_addr),
    .rdata (rf_a_q)
  );

  scmips_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (1'b1),
    .raddr (rt_addr),
    .rdata (rf_b_q)
  );

  scmips_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (en_pipe),
    .raddr (dm_idx),
    .rdata (dm_q)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
      s4_v_r     <= 1'b0;
      pc_r       <= 32'd0;
      count_r    <= 32'd0;
      wb_v_r     <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_W'(CLR_N - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        pc_r    <= ex.npc;
        count_r <= ex.cnt;
      end
      if (en_pipe) begin
        s2_v_r <= s1_adv;
        s3_v_r <= s2_v_r;
        s4_v_r <= s3_v_r;
      end
      wb_v_r <= rf_commit;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= in_action;
      s1_insn_r   <= in_instruction_word;
      s1_lidx_r   <= in_load_index;
      s1_lval_r   <= in_load_value;
    end
    if (en_pipe) begin
      s2_r     <= ex;
      s3_r     <= s2_r;
      s3_q_r   <= q_nxt;
      s4_r     <= s3_r;
      s4_tgt_r <= rem[4:0];
    end
    wb_idx_r <= s4_r.rf_dst;
    wb_val_r <= commit_val;
  end

  assign out_valid          = s4_v_r;
  assign out_next_pc        = s4_r.npc;
  assign out_write_kind     = s4_r.rf_we ? WK_REG : (s4_r.dm_we ? WK_MEM : WK_NONE);
  assign out_write_target   = s4_r.rf_we ? s4_r.rf_dst : (s4_r.dm_we ? s4_tgt_r : 5'd0);
  assign out_write_value    = s4_r.rf_we ? commit_val : (s4_r.dm_we ? s4_r.dm_val : 32'd0);
  assign out_redirected     = s4_r.redir;
  assign out_illegal        = s4_r.bad;
  assign out_executed_count = s4_r.cnt;

endmodule

// ===== sv/scmips_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the register file copies and the data memory; no dependencies.
// Read returns the contents before a write at the same edge.
module scmips_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/scmips_exec.sv =====
// Execute logic: decodes one transaction and works out pc, count and the write it makes.
// Purely combinational; depends on scmips_pkg for codes and the ex_t result struct.
module scmips_exec (
  input  logic [1:0]        action_i,
  input  logic [31:0]       insn_i,
  input  logic [4:0]        lidx_i,
  input  logic [31:0]       lval_i,
  input  logic [31:0]       pc_i,
  input  logic [31:0]       cnt_i,
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  output scmips_pkg::ex_t   ex_o
);
  import scmips_pkg::*;

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [31:0] imm;
  logic [31:0] seq;
  logic [31:0] sum;

  assign op  = insn_i[31:26];
  assign fn  = insn_i[5:0];
  assign rt  = insn_i[20:16];
  assign rd  = insn_i[15:11];
  assign imm = {{16{insn_i[15]}}, insn_i[15:0]};
  assign seq = pc_i + 32'd4;
  assign sum = a_i + imm;

  always_comb begin
    ex_o     = '0;
    ex_o.npc = pc_i;
    ex_o.cnt = cnt_i;
    case (action_i)
      ACT_EXEC: begin
        ex_o.npc = seq;
        case (op)
          OP_RTYPE: begin
            ex_o.rf_dst = rd;
            ex_o.rf_we  = (rd != 5'd0);
            case (fn)
              FN_ADD: ex_o.rf_val = a_i + b_i;
              FN_SUB: ex_o.rf_val = a_i - b_i;
              FN_AND: ex_o.rf_val = a_i & b_i;
              FN_OR:  ex_o.rf_val = a_i | b_i;
              FN_NOR: ex_o.rf_val = ~(a_i | b_i);
              FN_SLT: ex_o.rf_val = {31'd0, ($signed(a_i) < $signed(b_i))};
              default: begin
                ex_o.rf_we = 1'b0;
                ex_o.bad   = 1'b1;
              end
            endcase
          end
          OP_LW: begin
            ex_o.rf_ld   = 1'b1;
            ex_o.rf_dst  = rt;
            ex_o.rf_we   = (rt != 5'd0);
            ex_o.dm_word = sum[31:2];
          end
          OP_SW: begin
            ex_o.dm_we   = 1'b1;
            ex_o.dm_word = sum[31:2];
            ex_o.dm_val  = b_i;
          end
          OP_BEQ: begin
            if (a_i == b_i) begin
              ex_o.npc   = seq + {imm[29:0], 2'b00};
              ex_o.redir = 1'b1;
            end
          end
          OP_J, OP_JAL: begin
            ex_o.npc   = {seq[31:28], insn_i[25:0], 2'b00};
            ex_o.redir = 1'b1;
          end
          default: ex_o.bad = 1'b1;
        endcase
        if (!ex_o.bad) begin
          ex_o.cnt = cnt_i + 32'd1;
        end
      end
      ACT_LDREG: begin
        if (lidx_i != 5'd0) begin
          ex_o.rf_we  = 1'b1;
          ex_o.rf_dst = lidx_i;
          ex_o.rf_val = lval_i;
        end
      end
      ACT_LDMEM: begin
        ex_o.dm_we   = 1'b1;
        ex_o.dm_word = 30'(lidx_i);
        ex_o.dm_val  = lval_i;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/scmips_checker.sv =====
// Port-level checks for the MIPS subset core, attached to the top level by bind.
// Depends on scmips_pkg for write-kind codes.
module scmips_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [31:0]        out_next_pc,
  input logic [1:0]         out_write_kind,
  input logic [4:0]         out_write_target,
  input logic signed [31:0] out_write_value,
  input logic               out_redirected,
  input logic               out_illegal,
  input logic [31:0]        out_executed_count
);
  import scmips_pkg::*;

  logic        out_acc;
  logic        have_r;
  logic [31:0] last_r;

  assign out_acc = out_valid && !out_stall;

  // Remember the count of the last delivered transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (out_acc) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      last_r <= out_executed_count;
    end
  end

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("result offered or input open straight after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_next_pc)
      && $stable(out_write_value) && $stable(out_executed_count))
    else $error("stalled result transaction changed");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_kind == WK_NONE |->
      out_write_target == 5'd0 && out_write_value == 32'sd0)
    else $error("empty write reports a target or value");

  a_illegal_inert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_illegal |-> out_write_kind == WK_NONE && !out_redirected)
    else $error("illegal instruction wrote state or redirected");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && have_r |->
      out_executed_count == last_r || out_executed_count == last_r + 32'd1)
    else $error("instruction count moved by more than one");

endmodule

bind single_cycle_mips_subset_core scmips_checker u_scmips_checker (.*);
